[design/fpa_pkg.sv]
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int MAX_RING  = 8;
   localparam int FORK_W    = $clog2(MAX_RING);
   localparam int IDX_W     = 4;
   localparam int CNT_W     = $clog2(MAX_RING + 1);
   localparam int VAL_W     = 32;
   localparam int TOTAL_MAX = 15;

   // configuration register map (byte addresses)
   localparam logic [1:0] CSR_RING_SIZE = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   // one write port and one registered read port into the wait list
   typedef struct packed {
      logic              wr_en;
      logic [FORK_W-1:0] wr_addr;
      logic [IDX_W-1:0]  wr_index;
      logic [VAL_W-1:0]  wr_value;
      logic              rd_en;
      logic [FORK_W-1:0] rd_addr;
   } wl_cmd_type;

   // outcome of the fork check for one candidate requester
   typedef struct packed {
      logic              idx_ok;
      logic              free;
      logic [FORK_W-1:0] lo;
      logic [FORK_W-1:0] hi;
   } fork_chk_type;

endpackage

[design/fork_pair_arbiter.sv]
`timescale 1ns / 1ps
// Steps: a request or a bad index goes through decide, then finish; a release
// goes on to scan read/check over the wait list, then compaction read/write
// through one wait-list port, before finish.
// Throughput: one item at a time, req_tready high only while idle; the next item
// can transfer once the result loads, which waits under result back-pressure.
// Reset (synchronous, active high): forks free, wait list empty, sums zero, ring_size 8.
module fork_pair_arbiter import fpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // requester[3:0], contribution[35:4], zero pad
   input  logic        req_tuser,  // mode: 0 request, 1 release
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // grant_valid[0], granted_index[4:1], was_queued[5], rejected[6],
   // running_sum[38:7], waiting_count[42:39], all_done[43], zero pad
   output logic [47:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   state_type state_ff, state_in;

   // configuration
   logic [3:0]       ring_size_ff;
   logic [CNT_W-1:0] ring;

   // latched item
   logic             item_mode_ff;
   logic [IDX_W-1:0] item_req_ff;
   logic [VAL_W-1:0] item_val_ff;

   // arbiter state
   logic [MAX_RING-1:0] busy_ff;
   logic [CNT_W-1:0]    len_ff;
   logic [3:0]          total_ff;
   logic [VAL_W-1:0]    sum_ff;

   // scan / compaction pointers
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] m_ff;

   // per-item result flags
   logic [IDX_W-1:0] res_grant_ff;
   logic             res_queued_ff;
   logic             res_rej_ff;

   // result register
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   wl_cmd_type       wl_cmd;
   logic [IDX_W-1:0] rd_index;
   logic [VAL_W-1:0] rd_value;

   fork_chk_type        fk;
   logic [MAX_RING-1:0] pair_mask;
   logic [IDX_W-1:0]    cand;
   logic [VAL_W-1:0]    addend;
   logic [VAL_W-1:0]    sum_in;
   logic                out_free;
   logic                load_rsp;
   logic                all_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- configuration port --------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_prdata = {28'd0, ring_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= 4'd8;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_RING_SIZE)) begin
         ring_size_ff <= csr_pwdata[3:0];
      end
   end

   // effective ring: 0 acts as 1, above MAX_RING clamps
   always_comb begin
      if (ring_size_ff == 4'd0) begin
         ring = CNT_W'(1);
      end else if (ring_size_ff > 4'(MAX_RING)) begin
         ring = CNT_W'(MAX_RING);
      end else begin
         ring = CNT_W'(ring_size_ff);
      end
   end

   // ---- shared fork check and adder ----------------------------------------
   // candidate is the latched item, or the waiter just read during a scan
   assign cand   = (state_ff == ST_SCAN_CHK) ? rd_index : item_req_ff;
   assign addend = (state_ff == ST_SCAN_CHK) ? rd_value : item_val_ff;
   assign sum_in = sum_ff + addend;

   fpa_fork_unit u_fork (
      .cand (cand),
      .ring (ring),
      .busy (busy_ff),
      .chk  (fk)
   );

   // both forks of the candidate; one bit when the ring has a single seat
   assign pair_mask = (MAX_RING'(1) << fk.lo) | (MAX_RING'(1) << fk.hi);

   fpa_wait_list u_list (
      .clock    (clock),
      .cmd      (wl_cmd),
      .rd_index (rd_index),
      .rd_value (rd_value)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign all_done = (CNT_W'(total_ff) >= ring) && (len_ff == '0) && (busy_ff == '0);

   // ---- next state ---------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (fk.idx_ok && item_mode_ff) state_in = ST_SCAN_RD;
            else                           state_in = ST_FINISH;
         end
         ST_SCAN_RD: begin
            if (k_ff < len_ff) state_in = ST_SCAN_CHK;
            else               state_in = ST_FINISH;
         end
         ST_SCAN_CHK: begin
            if (fk.idx_ok && fk.free) state_in = ST_SHIFT_RD;
            else                      state_in = ST_SCAN_RD;
         end
         ST_SHIFT_RD: begin
            if (m_ff + CNT_W'(1) < len_ff) state_in = ST_SHIFT_WR;
            else                           state_in = ST_FINISH;
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- outputs: wait-list port and result load ----------------------------
   always_comb begin
      logic [CNT_W-1:0] m_next;
      m_next          = m_ff + CNT_W'(1);
      wl_cmd          = '0;
      wl_cmd.wr_index = item_req_ff;
      wl_cmd.wr_value = item_val_ff;
      load_rsp        = 1'b0;
      unique case (state_ff)
         ST_DECIDE: begin
            // queue a blocked request at the tail
            wl_cmd.wr_en   = fk.idx_ok && !item_mode_ff && !fk.free
                             && (len_ff < CNT_W'(MAX_RING));
            wl_cmd.wr_addr = len_ff[FORK_W-1:0];
         end
         ST_SCAN_RD: begin
            wl_cmd.rd_en   = (k_ff < len_ff);
            wl_cmd.rd_addr = k_ff[FORK_W-1:0];
         end
         ST_SHIFT_RD: begin
            wl_cmd.rd_en   = (m_next < len_ff);
            wl_cmd.rd_addr = m_next[FORK_W-1:0];
         end
         ST_SHIFT_WR: begin
            // move entry m+1 down to m
            wl_cmd.wr_en    = 1'b1;
            wl_cmd.wr_addr  = m_ff[FORK_W-1:0];
            wl_cmd.wr_index = rd_index;
            wl_cmd.wr_value = rd_value;
         end
         ST_FINISH: load_rsp = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- arbiter datapath ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         len_ff        <= '0;
         total_ff      <= '0;
         sum_ff        <= '0;
         res_grant_ff  <= '0;
         res_queued_ff <= 1'b0;
         res_rej_ff    <= 1'b0;
         k_ff          <= '0;
         m_ff          <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  res_grant_ff  <= '0;
                  res_queued_ff <= 1'b0;
                  res_rej_ff    <= 1'b0;
               end
            end
            ST_DECIDE: begin
               priority if (!fk.idx_ok) begin
                  res_rej_ff <= 1'b1;
               end else if (item_mode_ff) begin
                  // release frees both forks whoever held them
                  busy_ff <= busy_ff & ~pair_mask;
                  k_ff    <= '0;
               end else if (fk.free) begin
                  busy_ff      <= busy_ff | pair_mask;
                  sum_ff       <= sum_in;
                  res_grant_ff <= item_req_ff;
                  if (total_ff != 4'(TOTAL_MAX)) total_ff <= total_ff + 4'd1;
               end else if (len_ff < CNT_W'(MAX_RING)) begin
                  len_ff        <= len_ff + CNT_W'(1);
                  res_queued_ff <= 1'b1;
                  if (total_ff != 4'(TOTAL_MAX)) total_ff <= total_ff + 4'd1;
               end else begin
                  res_rej_ff <= 1'b1;
               end
            end
            ST_SCAN_CHK: begin
               // stale waiters outside the ring fail idx_ok and stay put
               if (fk.idx_ok && fk.free) begin
                  busy_ff      <= busy_ff | pair_mask;
                  sum_ff       <= sum_in;
                  res_grant_ff <= rd_index;
                  m_ff         <= k_ff;
               end else begin
                  k_ff <= k_ff + CNT_W'(1);
               end
            end
            ST_SHIFT_RD: begin
               if (!(m_ff + CNT_W'(1) < len_ff)) len_ff <= len_ff - CNT_W'(1);
            end
            ST_SHIFT_WR: m_ff <= m_ff + CNT_W'(1);
            default: ;
         endcase
      end
   end

   // item latch, payload only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_mode_ff <= req_tuser;
         item_req_ff  <= req_tdata[3:0];
         item_val_ff  <= req_tdata[35:4];
      end
   end

   // ---- result register ----------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= {4'd0, all_done, len_ff, sum_ff, res_rej_ff, res_queued_ff,
                         res_grant_ff, (res_grant_ff != '0)};
      end
   end

endmodule

[design/fpa_wait_list.sv]
`timescale 1ns / 1ps
module fpa_wait_list import fpa_pkg::*; (
   input  logic             clock,
   input  wl_cmd_type       cmd,
   output logic [IDX_W-1:0] rd_index,
   output logic [VAL_W-1:0] rd_value
);

   logic [IDX_W-1:0] wait_index_ff [MAX_RING];
   logic [VAL_W-1:0] wait_value_ff [MAX_RING];
   logic [IDX_W-1:0] rd_index_ff;
   logic [VAL_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         wait_index_ff[cmd.wr_addr] <= cmd.wr_index;
         wait_value_ff[cmd.wr_addr] <= cmd.wr_value;
      end
      if (cmd.rd_en) begin
         rd_index_ff <= wait_index_ff[cmd.rd_addr];
         rd_value_ff <= wait_value_ff[cmd.rd_addr];
      end
   end

   assign rd_index = rd_index_ff;
   assign rd_value = rd_value_ff;

endmodule

[design/fpa_fork_unit.sv]
`timescale 1ns / 1ps
module fpa_fork_unit import fpa_pkg::*; (
   input  logic [IDX_W-1:0]    cand,
   input  logic [CNT_W-1:0]    ring,
   input  logic [MAX_RING-1:0] busy,
   output fork_chk_type        chk
);

   logic [IDX_W-1:0] cand_m1;
   logic [CNT_W-1:0] cand_ext;

   always_comb begin
      cand_m1    = cand - IDX_W'(1);
      cand_ext   = CNT_W'(cand);
      chk.idx_ok = (cand != '0) && (cand_ext <= ring) && (cand <= IDX_W'(MAX_RING));
      chk.lo     = cand_m1[FORK_W-1:0];
      // right fork wraps to fork 0 for the last seat of the ring
      chk.hi     = (cand_ext == ring) ? '0 : cand[FORK_W-1:0];
      chk.free   = !busy[chk.lo] && !busy[chk.hi];
   end

endmodule
